// ===== rtl/pfe_pkg.sv =====
// Shared types and constants for the planar framebuffer pixel engine.
// Item layouts, operation kinds, register indexes and the queued command format.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

  localparam int PLANE_DEPTH_DEFAULT = 8192;
  localparam int PLANE_COUNT         = 4;
  localparam int WORD_W              = 8 * PLANE_COUNT;

  localparam int WIDTH_W  = 10;
  localparam int HEIGHT_W = 9;
  localparam int STRIDE_W = 8;
  localparam int OFF_W    = 16;
  localparam int SUM_W    = 17;

  localparam int WIDTH_RESET  = 320;
  localparam int HEIGHT_RESET = 200;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // item kinds
  localparam logic [2:0] KIND_PIXEL = 3'd0;
  localparam logic [2:0] KIND_COPY  = 3'd1;
  localparam logic [2:0] KIND_OR    = 3'd2;
  localparam logic [2:0] KIND_READ  = 3'd3;
  localparam logic [2:0] KIND_RECT  = 3'd4;
  localparam logic [2:0] KIND_CLEAR = 3'd5;

  // configuration register indexes
  localparam logic REG_SURFACE_WIDTH  = 1'b0;
  localparam logic REG_SURFACE_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ERR,
    OP_PIXEL,
    OP_COPY,
    OP_OR,
    OP_READ,
    OP_RECT,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic        [2:0]  kind;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic        [3:0]  color;
    logic        [1:0]  plane;
    logic        [6:0]  byte_col;
    logic        [8:0]  row;
    logic        [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  plane_byte;
    logic [31:0] pixel_indices;
  } out_item_t;

  typedef struct packed {
    op_t                 op;
    logic [OFF_W-1:0]    addr;
    logic [2:0]          bit_pos;
    logic [3:0]          color;
    logic [1:0]          plane;
    logic [7:0]          data;
    logic [WIDTH_W-1:0]  x0;
    logic [WIDTH_W-1:0]  x1;
    logic [HEIGHT_W-1:0] y0;
    logic [HEIGHT_W-1:0] y1;
    logic [SUM_W-1:0]    base;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/pfe_front.sv =====
// Front end: accepts items, range-checks and clips them, and queues one command each.
// Depends on pfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfe_front #(
  parameter int PLANE_DEPTH = pfe_pkg::PLANE_DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire pfe_pkg::in_item_t             item,
  input  wire logic [pfe_pkg::WIDTH_W-1:0]   surface_width,
  input  wire logic [pfe_pkg::HEIGHT_W-1:0]  surface_height,
  input  wire logic [pfe_pkg::STRIDE_W-1:0]  stride,
  input  wire logic                          init_busy,
  input  wire logic                          q_full,
  output logic                               push,
  output pfe_pkg::cmd_t                      push_cmd
);
  import pfe_pkg::*;

  typedef enum logic {F_IDLE, F_PUSH} fstate_t;

  fstate_t          state;
  in_item_t         held;
  logic [SUM_W-1:0] prod;

  logic [HEIGHT_W-1:0] y_sel;

  logic               x_ok, y_ok, in_mem, byte_ok, rect_ok;
  logic [6:0]         col_sel;
  logic [SUM_W-1:0]   off_sum;
  logic signed [16:0] x0s, y0s, x1raw, y1raw, x1c, y1c, wd, ht;

  // row used for the offset product, picked from the incoming item
  always_comb begin
    case (item.kind)
      KIND_PIXEL: y_sel = item.pixel_y[8:0];
      KIND_RECT:  y_sel = item.pixel_y[15] ? '0 : item.pixel_y[8:0];
      default:    y_sel = item.row;
    endcase
  end

  assign item_stall = (state != F_IDLE) || init_busy;
  assign push       = (state == F_PUSH) && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (item_valid && !init_busy) begin
            held  <= item;
            prod  <= {8'b0, y_sel} * {9'b0, stride};
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_comb begin
    x_ok    = !held.pixel_x[15] && ({1'b0, held.pixel_x[14:0]} < {6'b0, surface_width});
    y_ok    = !held.pixel_y[15] && ({1'b0, held.pixel_y[14:0]} < {7'b0, surface_height});
    col_sel = (held.kind == KIND_PIXEL) ? held.pixel_x[9:3] : held.byte_col;
    off_sum = prod + {10'b0, col_sel};
    in_mem  = off_sum < SUM_W'(PLANE_DEPTH);
    byte_ok = ({1'b0, held.byte_col} < stride) && (held.row < surface_height) && in_mem;

    // clip the rectangle to the surface
    wd    = {7'b0, surface_width};
    ht    = {8'b0, surface_height};
    x0s   = held.pixel_x[15] ? '0 : {1'b0, held.pixel_x};
    y0s   = held.pixel_y[15] ? '0 : {1'b0, held.pixel_y};
    x1raw = {held.pixel_x[15], held.pixel_x} + {held.rect_width[15], held.rect_width};
    y1raw = {held.pixel_y[15], held.pixel_y} + {held.rect_height[15], held.rect_height};
    x1c   = (x1raw > wd) ? wd : x1raw;
    y1c   = (y1raw > ht) ? ht : y1raw;
    rect_ok = !held.rect_width[15] && (held.rect_width != '0) &&
              !held.rect_height[15] && (held.rect_height != '0) &&
              (x0s < x1c) && (y0s < y1c);

    push_cmd         = '0;
    push_cmd.op      = OP_NOP;
    push_cmd.addr    = off_sum[OFF_W-1:0];
    push_cmd.bit_pos = held.pixel_x[2:0];
    push_cmd.color   = held.color;
    push_cmd.plane   = held.plane;
    push_cmd.data    = held.data_byte;
    push_cmd.x0      = x0s[WIDTH_W-1:0];
    push_cmd.x1      = x1c[WIDTH_W-1:0];
    push_cmd.y0      = y0s[HEIGHT_W-1:0];
    push_cmd.y1      = y1c[HEIGHT_W-1:0];
    push_cmd.base    = prod;

    case (held.kind)
      KIND_PIXEL: push_cmd.op = (x_ok && y_ok && in_mem) ? OP_PIXEL : OP_NOP;
      KIND_COPY:  push_cmd.op = byte_ok ? OP_COPY : OP_ERR;
      KIND_OR:    push_cmd.op = byte_ok ? OP_OR : OP_ERR;
      KIND_READ:  push_cmd.op = byte_ok ? OP_READ : OP_ERR;
      KIND_RECT:  push_cmd.op = rect_ok ? OP_RECT : OP_NOP;
      KIND_CLEAR: push_cmd.op = OP_CLEAR;
      default:    push_cmd.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pfe_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on pfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfe_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire pfe_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output pfe_pkg::cmd_t      head,
  output logic               empty
);
  import pfe_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_cmd;
        wr_ptr          <= wr_ptr + QPTR_W'(1);
      end
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pfe_back.sv =====
// Back end: owns the plane memory, runs queued commands and holds the result register.
// Depends on pfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfe_back #(
  parameter int PLANE_DEPTH = pfe_pkg::PLANE_DEPTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [pfe_pkg::STRIDE_W-1:0] stride,
  input  wire logic                         q_empty,
  input  wire pfe_pkg::cmd_t                head,
  output logic                              pop,
  output logic                              init_busy,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output pfe_pkg::out_item_t                result
);
  import pfe_pkg::*;

  localparam int AW = $clog2(PLANE_DEPTH);

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_ACCESS,
    B_MODIFY,
    B_RECT_ADDR,
    B_RECT_MODIFY,
    B_CLEAR,
    B_DONE
  } bstate_t;

  bstate_t              state;
  cmd_t                 cmd;
  logic [AW-1:0]        cur_addr;
  logic [WIDTH_W-1:0]   x;
  logic [HEIGHT_W-1:0]  y;
  logic [SUM_W-1:0]     base;
  out_item_t            res;

  logic [WORD_W-1:0] mem [PLANE_DEPTH];
  logic [WORD_W-1:0] rdata;

  logic [SUM_W-1:0]  roff;
  logic              rect_in;
  logic              x_last, y_last, last_addr;
  logic              mem_we, rd_en;
  logic [AW-1:0]     raddr;
  logic [WORD_W-1:0] wdata;

  function automatic logic [WORD_W-1:0] put_pixel(input logic [WORD_W-1:0] w,
                                                  input logic [2:0] bp,
                                                  input logic [3:0] color);
    logic [WORD_W-1:0] r;
    logic [7:0]        mask;
    r    = w;
    mask = 8'h80 >> bp;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      if (color[p]) r[8*p +: 8] = w[8*p +: 8] | mask;
      else          r[8*p +: 8] = w[8*p +: 8] & ~mask;
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] copy_byte(input logic [WORD_W-1:0] w,
                                                  input logic [1:0] plane,
                                                  input logic [7:0] data);
    logic [WORD_W-1:0] r;
    r = w;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      if (plane == 2'(p)) r[8*p +: 8] = data;
    end
    return r;
  endfunction

  // gather one bit per plane into each nibble, leftmost pixel on top
  function automatic logic [31:0] unpack_pixels(input logic [WORD_W-1:0] w);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        r[28 - 4*i + p] = w[8*p + 7 - i];
      end
    end
    return r;
  endfunction

  always_comb begin
    roff      = base + {10'b0, x[WIDTH_W-1:3]};
    rect_in   = roff < SUM_W'(PLANE_DEPTH);
    x_last    = ({1'b0, x} + (WIDTH_W+1)'(1)) == {1'b0, cmd.x1};
    y_last    = ({1'b0, y} + (HEIGHT_W+1)'(1)) == {1'b0, cmd.y1};
    last_addr = (cur_addr == AW'(PLANE_DEPTH - 1));
    pop       = (state == B_IDLE) && !q_empty;
    init_busy = (state == B_INIT);
    rd_en     = (state == B_ACCESS) || ((state == B_RECT_ADDR) && rect_in);
    raddr     = (state == B_RECT_ADDR) ? roff[AW-1:0] : cur_addr;

    mem_we = 1'b0;
    wdata  = rdata;
    case (state)
      B_INIT: begin
        mem_we = 1'b1;
        wdata  = '0;
      end
      B_CLEAR: begin
        mem_we = 1'b1;
        wdata  = {PLANE_COUNT{cmd.data}};
      end
      B_MODIFY: begin
        mem_we = (cmd.op != OP_READ);
        case (cmd.op)
          OP_PIXEL: wdata = put_pixel(rdata, cmd.bit_pos, cmd.color);
          OP_COPY:  wdata = copy_byte(rdata, cmd.plane, cmd.data);
          OP_OR:    wdata = rdata | ({24'b0, cmd.data} << {cmd.plane, 3'b000});
          default:  wdata = rdata;
        endcase
      end
      B_RECT_MODIFY: begin
        mem_we = 1'b1;
        wdata  = put_pixel(rdata, x[2:0], cmd.color);
      end
      default: begin
        mem_we = 1'b0;
        wdata  = rdata;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[cur_addr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_INIT;
      cur_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != B_DONE)) result_valid <= 1'b0;
      case (state)
        B_INIT: begin
          cur_addr <= cur_addr + AW'(1);
          if (last_addr) state <= B_IDLE;
        end
        B_IDLE: begin
          if (!q_empty) begin
            cmd <= head;
            res <= '{status: (head.op == OP_ERR), plane_byte: 8'h00, pixel_indices: 32'h0};
            case (head.op)
              OP_ERR: begin
                state <= B_DONE;
              end
              OP_PIXEL, OP_COPY, OP_OR, OP_READ: begin
                cur_addr <= head.addr[AW-1:0];
                state    <= B_ACCESS;
              end
              OP_RECT: begin
                x     <= head.x0;
                y     <= head.y0;
                base  <= head.base;
                state <= B_RECT_ADDR;
              end
              OP_CLEAR: begin
                cur_addr <= '0;
                state    <= B_CLEAR;
              end
              default: state <= B_DONE;
            endcase
          end
        end
        B_ACCESS: state <= B_MODIFY;
        B_MODIFY: begin
          if (cmd.op == OP_READ) begin
            res <= '{status: 1'b0, plane_byte: rdata[{cmd.plane, 3'b000} +: 8],
                     pixel_indices: unpack_pixels(rdata)};
          end
          state <= B_DONE;
        end
        B_RECT_ADDR, B_RECT_MODIFY: begin
          if (state == B_RECT_ADDR) cur_addr <= roff[AW-1:0];
          if ((state == B_RECT_ADDR) && rect_in) begin
            state <= B_RECT_MODIFY;
          end else if (x_last) begin
            // wrap to the next row of the clipped area
            x    <= cmd.x0;
            y    <= y + HEIGHT_W'(1);
            base <= base + {9'b0, stride};
            state <= y_last ? B_DONE : B_RECT_ADDR;
          end else begin
            x     <= x + WIDTH_W'(1);
            state <= B_RECT_ADDR;
          end
        end
        B_CLEAR: begin
          cur_addr <= cur_addr + AW'(1);
          if (last_addr) state <= B_DONE;
        end
        B_DONE: begin
          // hold until the output register is free
          if (!result_valid || !result_stall) begin
            result       <= res;
            result_valid <= 1'b1;
            state        <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/planar_framebuffer_pixel_engine_top.sv =====
// Top level of the four-plane framebuffer pixel engine: surface registers and wiring.
// Depends on pfe_pkg, pfe_front, pfe_queue and pfe_back.
//
//   channel  | signals                         | direction
//   ---------+---------------------------------+----------
//   item     | item_valid, item_stall, item    | in
//   result   | result_valid, result_stall, ... | out
//   config   | cfg_we, cfg_index, cfg_data     | in
//
// The front end takes a new item only after the command for the held one is queued;
// one command is queued per item. The back end runs a pixel or byte operation as a
// read-modify-write of one memory word, sends an error or no-op straight to the result,
// walks a clipped rectangle pixel by pixel (no memory access for a pixel past the end of
// memory), and sweeps all of memory for a clear. After reset the plane memory is swept
// to zero; item_stall stays high during that sweep. A stalled result holds in the output
// register while the front end keeps filling the queue.
`timescale 1ns / 1ps
`default_nettype none

module planar_framebuffer_pixel_engine_top #(
  parameter int PLANE_DEPTH = pfe_pkg::PLANE_DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire pfe_pkg::in_item_t           item,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output pfe_pkg::out_item_t               result,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [pfe_pkg::WIDTH_W-1:0] cfg_data
);
  import pfe_pkg::*;

  logic [WIDTH_W-1:0]  surface_width;
  logic [HEIGHT_W-1:0] surface_height;
  logic [STRIDE_W-1:0] stride;
  logic [WIDTH_W:0]    width_round;

  logic init_busy, q_full, q_empty, push, pop;
  cmd_t push_cmd, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= WIDTH_W'(WIDTH_RESET);
      surface_height <= HEIGHT_W'(HEIGHT_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SURFACE_WIDTH:  surface_width  <= cfg_data;
        REG_SURFACE_HEIGHT: surface_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // bytes per row: width rounded up to whole bytes
  assign width_round = {1'b0, surface_width} + (WIDTH_W+1)'(7);
  assign stride      = width_round[WIDTH_W:3];

  pfe_front #(.PLANE_DEPTH(PLANE_DEPTH)) u_front (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item),
    .surface_width  (surface_width),
    .surface_height (surface_height),
    .stride         (stride),
    .init_busy      (init_busy),
    .q_full         (q_full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  pfe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  pfe_back #(.PLANE_DEPTH(PLANE_DEPTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .stride       (stride),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .init_busy    (init_busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
